// ===== hdl/mss_pkg.sv =====
// Shared types and constants for the masked signature scanner.
// Used by every module of the block; has no dependencies of its own.
package mss_pkg;

  localparam int MAX_SIG_WORDS  = 16;
  localparam int MAX_CANDIDATES = 256;

  localparam int WORD_W     = 32;
  localparam int ADDR_W     = 64;
  localparam int CMD_W      = 3;
  localparam int SLOT_W     = 4;
  localparam int RSLOT_W    = 8;
  localparam int CFG_W      = 5;
  localparam int LEN_W      = $clog2(MAX_SIG_WORDS + 1);
  localparam int SIG_IDX_W  = $clog2(MAX_SIG_WORDS);
  localparam int CNT_W      = 9;
  localparam int CAND_IDX_W = $clog2(MAX_CANDIDATES);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEGMENT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_CLEAR,
    OP_SEGMENT,
    OP_SCAN,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  pattern_slot;
    logic [WORD_W-1:0]  pattern_value;
    logic [WORD_W-1:0]  pattern_mask;
    logic [WORD_W-1:0]  data_word;
    logic [ADDR_W-1:0]  word_address;
    logic [RSLOT_W-1:0] read_slot;
  } in_item_t;

  typedef struct packed {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic [CNT_W-1:0]  candidate_total;
    logic              list_overflow;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  word;
    logic [ADDR_W-1:0]  addr;
    logic [RSLOT_W-1:0] rslot;
  } q_entry_t;

  typedef struct packed {
    logic valid;
  } q_status_t;

  typedef struct packed {
    logic pop;
  } q_ctrl_t;

endpackage

// ===== hdl/mss_front.sv =====
// Front end: accepts requests, decodes the command and queues the request.
// Depends on mss_pkg.
module mss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mss_pkg::in_item_t in_data,
  output mss_pkg::q_status_t q_stat,
  input  mss_pkg::q_ctrl_t  q_ctrl,
  output mss_pkg::q_entry_t q_head
);
  import mss_pkg::*;

  q_entry_t             q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  q_entry_t             entry;
  logic                 push;
  logic                 pop;

  always_comb begin
    entry.slot  = in_data.pattern_slot;
    entry.value = in_data.pattern_value;
    entry.mask  = in_data.pattern_mask;
    entry.word  = in_data.data_word;
    entry.addr  = in_data.word_address;
    entry.rslot = in_data.read_slot;
    unique case (in_data.command)
      CMD_LOAD:    entry.op = OP_LOAD;
      CMD_CLEAR:   entry.op = OP_CLEAR;
      CMD_SEGMENT: entry.op = OP_SEGMENT;
      CMD_SCAN:    entry.op = OP_SCAN;
      CMD_READ:    entry.op = OP_READ;
      default:     entry.op = OP_NONE;
    endcase
  end

  assign in_stall     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push         = in_valid && !in_stall;
  assign pop          = q_ctrl.pop;
  assign q_stat.valid = (cnt_r != '0);
  assign q_head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== hdl/mss_back.sv =====
// Back end: signature and window registers, parallel masked compare,
// candidate memory and the output register. Depends on mss_pkg.
module mss_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [mss_pkg::CFG_W-1:0] cfg_data,
  input  mss_pkg::q_status_t q_stat,
  output mss_pkg::q_ctrl_t   q_ctrl,
  input  mss_pkg::q_entry_t  q_head,
  output logic               out_valid,
  input  logic               out_stall,
  output mss_pkg::out_item_t out_data
);
  import mss_pkg::*;

  logic [CFG_W-1:0]      plen_r;
  logic [WORD_W-1:0]     sig_val_r [MAX_SIG_WORDS];
  logic [WORD_W-1:0]     sig_mask_r [MAX_SIG_WORDS];
  logic [WORD_W-1:0]     win_r [MAX_SIG_WORDS];
  logic [WORD_W-1:0]     win_nxt [MAX_SIG_WORDS];
  logic [LEN_W-1:0]      fill_r, fill_nxt, fill_inc;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]     cand_mem [MAX_CANDIDATES];
  logic [ADDR_W-1:0]     rd_q_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic                  out_is_read_r;
  logic                  out_rd_ok_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_ovf_r;

  logic [LEN_W-1:0]      act_len;
  logic [SIG_IDX_W-1:0]  idx;
  logic                  hit;
  logic [ADDR_W-1:0]     maddr;
  logic                  exec;
  logic                  is_scan;
  logic                  do_store;
  logic                  rd_ok;
  logic                  list_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (LEN_W'(plen_r) == '0) begin
      act_len = LEN_W'(1);
    end else if (LEN_W'(plen_r) > LEN_W'(MAX_SIG_WORDS)) begin
      act_len = LEN_W'(MAX_SIG_WORDS);
    end else begin
      act_len = LEN_W'(plen_r);
    end
  end

  always_comb begin
    win_nxt[0] = q_head.word;
    for (int k = 1; k < MAX_SIG_WORDS; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    fill_inc = (fill_r < LEN_W'(MAX_SIG_WORDS)) ? fill_r + LEN_W'(1) : fill_r;
  end

  // signature word i lines up with the word act_len-1-i back from the newest
  always_comb begin
    idx = '0;
    hit = (fill_inc >= act_len);
    for (int i = 0; i < MAX_SIG_WORDS; i++) begin
      if (LEN_W'(i) < act_len) begin
        idx = SIG_IDX_W'(act_len - LEN_W'(1) - LEN_W'(i));
        if ((win_nxt[idx] & sig_mask_r[i]) != (sig_val_r[i] & sig_mask_r[i])) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign maddr     = q_head.addr - (ADDR_W'(act_len - LEN_W'(1)) << 2);
  assign exec      = q_stat.valid && (!out_valid_r || !out_stall);
  assign q_ctrl.pop = exec;
  assign is_scan   = (q_head.op == OP_SCAN);
  assign list_full = (cnt_r >= CNT_W'(MAX_CANDIDATES));
  assign do_store  = is_scan && hit && !list_full;
  assign rd_ok     = (CNT_W'(q_head.rslot) < cnt_r);

  always_comb begin
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    unique case (q_head.op)
      OP_CLEAR: begin
        fill_nxt = '0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end
      OP_SEGMENT: fill_nxt = '0;
      OP_SCAN: begin
        fill_nxt = fill_inc;
        if (hit) begin
          if (list_full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= CFG_W'(1);
      fill_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SIG_WORDS; i++) begin
        sig_val_r[i]  <= '0;
        sig_mask_r[i] <= '0;
        win_r[i]      <= '0;
      end
    end else begin
      if (cfg_valid) begin
        plen_r <= cfg_data;
      end
      if (exec) begin
        fill_r <= fill_nxt;
        cnt_r  <= cnt_nxt;
        ovf_r  <= ovf_nxt;
        unique case (q_head.op)
          OP_LOAD: begin
            sig_val_r[q_head.slot]  <= q_head.value;
            sig_mask_r[q_head.slot] <= q_head.mask;
          end
          OP_CLEAR: begin
            for (int i = 0; i < MAX_SIG_WORDS; i++) begin
              sig_val_r[i]  <= '0;
              sig_mask_r[i] <= '0;
              win_r[i]      <= '0;
            end
          end
          OP_SCAN: begin
            for (int i = 0; i < MAX_SIG_WORDS; i++) begin
              win_r[i] <= win_nxt[i];
            end
          end
          default: ;
        endcase
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_found_r   <= is_scan && hit;
      out_addr_r    <= (is_scan && hit) ? maddr : '0;
      out_is_read_r <= (q_head.op == OP_READ);
      out_rd_ok_r   <= rd_ok;
      out_cnt_r     <= cnt_nxt;
      out_ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && do_store) begin
      cand_mem[cnt_r[CAND_IDX_W-1:0]] <= maddr;
    end
    if (exec) begin
      rd_q_r <= cand_mem[q_head.rslot[CAND_IDX_W-1:0]];
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.match_found     = out_found_r;
  assign out_data.match_address   = out_is_read_r ? (out_rd_ok_r ? rd_q_r : '0) : out_addr_r;
  assign out_data.candidate_total = out_cnt_r;
  assign out_data.list_overflow   = out_ovf_r;

endmodule

// ===== hdl/masked_signature_scanner.sv =====
// Top level of the masked signature scanner: decode queue plus execute unit.
// Depends on mss_pkg, mss_front and mss_back.
//
// Usage:
//   in_*  : request channel (valid/stall). Each request carries a command:
//           load pattern word, clear all, new segment, scan word, read candidate.
//   out_* : one result per request, in request order (valid/stall).
//   cfg_* : write channel for pattern_length; cfg_ready is always high.
//           Write it only while no request is in flight.
// Path: an accepted request is written to a queue entry, then its result to the
//   output register, where out_valid rises; a receiver stall can hold it in the queue.
// Throughput: one request per cycle; the two-entry decode queue and the
//   output register let requests flow while the receiver is ready.
// The window compare covers all signature words in parallel, combinationally;
//   candidate reads come from a 256 x 64 memory with a registered read.
// Reset: queue and output empty, pattern_length = 1, signature, window,
//   candidate count and overflow flag cleared.
// Receiver stall: the output holds its result; the queue fills and then
//   in_stall rises until the receiver takes results again.
module masked_signature_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mss_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [mss_pkg::CFG_W-1:0] cfg_data
);
  import mss_pkg::*;

  q_status_t q_stat;
  q_ctrl_t   q_ctrl;
  q_entry_t  q_head;

  mss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_ctrl   (q_ctrl),
    .q_head   (q_head)
  );

  mss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_ctrl    (q_ctrl),
    .q_head    (q_head),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/mss_checker.sv =====
// Port-level checks for the masked signature scanner, bound to the top level.
// Depends on mss_pkg and masked_signature_scanner.
module mss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input mss_pkg::out_item_t out_data
);
  import mss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match_found |->
      (out_data.candidate_total != '0) || out_data.list_overflow)
    else $error("match neither stored nor flagged");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_overflow |->
      out_data.candidate_total == CNT_W'(MAX_CANDIDATES))
    else $error("overflow with list not full");

endmodule

bind masked_signature_scanner mss_checker u_mss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
